[rtl/core/tcce_pkg.sv]
// Shared types and constants for the text console cursor engine.
package tcce_pkg;

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  localparam logic CFG_TEXT_COLOR   = 1'b0;
  localparam logic CFG_GFX_SUPPRESS = 1'b1;

  localparam int unsigned RESULT_BITS = 76;
  localparam int unsigned TDATA_BITS  = 80;

  localparam logic [7:0] TEXT_COLOR_RESET = 8'd10;

  // declared last field first so debug_byte lands in the low bits
  typedef struct packed {
    logic [10:0] cursor_pos;
    logic        cursor_we;
    logic [4:0]  top_row;
    logic [15:0] fill_value;
    logic [4:0]  fill_row;
    logic        fill_we;
    logic [15:0] cell_value;
    logic [6:0]  cell_col;
    logic [4:0]  cell_row;
    logic        cell_we;
    logic [7:0]  debug_byte;
  } result_t;

endpackage

[rtl/core/tcce_step.sv]
// Per-character cursor step: next cursor state and the result word.
module tcce_step import tcce_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic [7:0]                 char_code,
  input  logic [7:0]                 text_color,
  input  logic                       gfx_suppress,
  input  logic [$clog2(ROWS)-1:0]    row_cur,
  input  logic [$clog2(COLUMNS)-1:0] col_cur,
  input  logic [$clog2(ROWS)-1:0]    top_cur,
  output logic [$clog2(ROWS)-1:0]    row_nxt,
  output logic [$clog2(COLUMNS)-1:0] col_nxt,
  output logic [$clog2(ROWS)-1:0]    top_nxt,
  output result_t                    res
);

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLUMNS);
  localparam int PW = RW + CW;
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
  localparam logic [RW:0]   ROWS_W   = (RW + 1)'(ROWS);

  logic [RW:0]   phys_sum;
  logic [RW:0]   phys_row;
  logic [RW-1:0] top_inc;
  logic          scroll;
  logic [PW-1:0] pos;

  // ring position of the current logical row
  always_comb begin
    phys_sum = {1'b0, top_cur} + {1'b0, row_cur};
    phys_row = (phys_sum >= ROWS_W) ? (phys_sum - ROWS_W) : phys_sum;
    top_inc  = (top_cur == ROW_LAST) ? '0 : top_cur + 1'b1;
  end

  always_comb begin
    row_nxt = row_cur;
    col_nxt = col_cur;
    top_nxt = top_cur;
    scroll  = 1'b0;
    res     = '0;
    res.debug_byte = char_code;

    if (!gfx_suppress) begin
      case (char_code)
        CH_NEWLINE: begin
          col_nxt = '0;
          if (row_cur == ROW_LAST) begin
            scroll  = 1'b1;
          end else begin
            row_nxt = row_cur + 1'b1;
          end
        end
        CH_RETURN: begin
          col_nxt = '0;
        end
        CH_BACKSPACE: begin
          if (col_cur != '0) begin
            col_nxt        = col_cur - 1'b1;
            res.cell_we    = 1'b1;
            res.cell_row   = 5'(phys_row);
            res.cell_col   = 7'(col_cur - 1'b1);
            res.cell_value = {text_color, CH_SPACE};
          end
        end
        default: begin
          res.cell_we    = 1'b1;
          res.cell_row   = 5'(phys_row);
          res.cell_col   = 7'(col_cur);
          res.cell_value = {text_color, char_code};
          res.cursor_we  = 1'b1;
          if (col_cur == COL_LAST) begin
            col_nxt = '0;
            if (row_cur == ROW_LAST) begin
              scroll  = 1'b1;
            end else begin
              row_nxt = row_cur + 1'b1;
            end
          end else begin
            col_nxt = col_cur + 1'b1;
          end
        end
      endcase

      if (scroll) begin
        top_nxt        = top_inc;
        res.fill_we    = 1'b1;
        res.fill_row   = 5'(top_cur);
        res.fill_value = {text_color, CH_SPACE};
      end
    end

    pos = PW'(row_nxt) * PW'(COLUMNS) + PW'(col_nxt);
    if (res.cursor_we) begin
      res.cursor_pos = 11'(pos);
    end
    res.top_row = 5'(top_nxt);
  end

endmodule

[rtl/core/tcce_skid.sv]
// Output register with a skid slot so the input side keeps flowing.
module tcce_skid import tcce_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  result_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_data_r, out_data_nxt;
  result_t skid_data_r, skid_data_nxt;
  logic    take;

  assign in_ready  = !skid_valid_r;
  assign take      = in_valid && !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_data_nxt  = in_data;
        out_valid_nxt = take;
      end
    end else if (take) begin
      skid_data_nxt  = in_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

[rtl/core/text_console_cursor_engine_top.sv]
// Top level of the text console cursor engine.
//
//  channel  | direction | transaction when       | payload
//  ---------+-----------+------------------------+-------------------------------
//  in_      | slave     | in_tvalid & in_tready   | tdata[7:0] char_code
//  out_     | master    | out_tvalid & out_tready | tdata[79:0] result word
//  cfg_     | write     | cfg_we                  | cfg_index, cfg_wdata[7:0]
//
// One character per cycle while in_tready is high: the cursor step is a single
// combinational pass from the cursor/top registers to the output register, and
// the state updates on the same edge that takes the character. A skid slot
// behind the output register lets one more character in while a result is
// stalled; in_tready drops only when both are full. Synchronous active-low
// reset clears cursor, top offset and suppress; colour goes to TEXT_COLOR_RESET.
module text_console_cursor_engine_top import tcce_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] char_code
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] debug_byte, [8] cell_we, [13:9] cell_row, [20:14] cell_col,
  // [36:21] cell_value, [37] fill_we, [42:38] fill_row, [58:43] fill_value,
  // [63:59] top_row, [64] cursor_we, [75:65] cursor_pos, [79:76] zero
  output logic [79:0] out_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLUMNS);

  // cursor state; row is logical, top is the ring offset
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] top_r, top_nxt;

  logic [7:0] text_color_r;
  logic       gfx_suppress_r;

  result_t step_res;
  result_t out_res;
  logic    in_fire;

  assign in_fire = in_tvalid && in_tready;

  tcce_step #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_step (
    .char_code    (in_tdata),
    .text_color   (text_color_r),
    .gfx_suppress (gfx_suppress_r),
    .row_cur      (row_r),
    .col_cur      (col_r),
    .top_cur      (top_r),
    .row_nxt      (row_nxt),
    .col_nxt      (col_nxt),
    .top_nxt      (top_nxt),
    .res          (step_res)
  );

  // state moves only on an accepted character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      top_r <= '0;
    end else if (in_fire) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      top_r <= top_nxt;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r   <= TEXT_COLOR_RESET;
      gfx_suppress_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEXT_COLOR:   text_color_r   <= cfg_wdata;
        CFG_GFX_SUPPRESS: gfx_suppress_r <= cfg_wdata[0];
        default:          text_color_r   <= text_color_r;
      endcase
    end
  end

  tcce_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (step_res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = {(TDATA_BITS - RESULT_BITS)'(0), out_res};

endmodule

[rtl/core/tcce_checker.sv]
// Port-level checks for the text console cursor engine, bound to the top level.
module tcce_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // input only backs up when a result is waiting
  a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && $past(out_tvalid && !out_tready))
    else $error("in_tready low without a stalled result");

  // cursor update only comes with a printed cell
  a_cursor_with_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[64] |-> out_tdata[8] && out_tdata[7:0] == out_tdata[28:21])
    else $error("cursor update without matching cell write");

  // reset empties the output side
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // an accepted input always has room
  a_in_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted character left no result");

endmodule

bind text_console_cursor_engine_top tcce_checker u_tcce_checker (.*);

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the text console cursor engine: predicted results against the output stream.
module tb;
  import tcce_pkg::*;

  // Screen geometry as instantiated below
  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  // One item per cycle when neither side idles; random sender gaps and receiver
  // stalls can come with each transaction, and about 1300 items stay well under this.
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;    // [7:0] char_code
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [7:0] debug_byte, [8] cell_we, [13:9] cell_row, [20:14] cell_col,
  // [36:21] cell_value, [37] fill_we, [42:38] fill_row, [58:43] fill_value,
  // [63:59] top_row, [64] cursor_we, [75:65] cursor_pos, [79:76] zero
  logic [79:0] out_tdata;
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = CFG_TEXT_COLOR;
  logic [7:0]  cfg_wdata  = '0;

  text_console_cursor_engine_top #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Shadow of the console: logical cursor, ring top and the two registers
  logic [4:0] cur_row   = '0;
  logic [6:0] cur_col   = '0;
  logic [4:0] ring_top  = '0;
  logic [7:0] attr      = TEXT_COLOR_RESET;
  logic       gfx_off   = 1'b0;

  result_t    screen_ops_q[$];   // predicted result words, oldest first
  int         mismatches = 0;
  int         stall_left = 0;
  bit         bursts_on  = 1'b1; // random idling on both sides

  // 2 ns clock
  initial begin
    forever #1 clk = ~clk;
  end

  // Run guard
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[text_console_cursor_engine_top] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Console prediction
  // ---------------------------------------------------------------------------

  // Physical row of a logical row in the ring
  function automatic logic [4:0] ring_row(input logic [4:0] lrow);
    int s;
    s = int'(ring_top) + int'(lrow);
    if (s >= ROWS) s -= ROWS;
    return s[4:0];
  endfunction

  // Step to the next logical row; on the last row the ring turns instead and
  // the old top row is handed back for blanking.
  function automatic bit line_feed(output logic [4:0] freed);
    freed = ring_top;
    if (cur_row == ROWS - 1) begin
      ring_top = (ring_top == ROWS - 1) ? 5'd0 : ring_top + 5'd1;
      return 1'b1;
    end
    cur_row = cur_row + 5'd1;
    return 1'b0;
  endfunction

  function automatic result_t console_step(input logic [7:0] ch);
    result_t    r;
    logic [4:0] freed;
    int         pos;
    r = '0;
    r.debug_byte = ch;
    if (!gfx_off) begin
      case (ch)
        CH_NEWLINE: begin
          cur_col = '0;
          if (line_feed(freed)) begin
            r.fill_we    = 1'b1;
            r.fill_row   = freed;
            r.fill_value = {attr, CH_SPACE};
          end
        end
        CH_RETURN: cur_col = '0;
        CH_BACKSPACE: begin
          // nothing at all at column 0
          if (cur_col != 0) begin
            cur_col      = cur_col - 7'd1;
            r.cell_we    = 1'b1;
            r.cell_row   = ring_row(cur_row);
            r.cell_col   = cur_col;
            r.cell_value = {attr, CH_SPACE};
          end
        end
        default: begin
          // cell goes at the old position, wrap and scroll follow
          r.cell_we    = 1'b1;
          r.cell_row   = ring_row(cur_row);
          r.cell_col   = cur_col;
          r.cell_value = {attr, ch};
          if (cur_col == COLUMNS - 1) begin
            cur_col = '0;
            if (line_feed(freed)) begin
              r.fill_we    = 1'b1;
              r.fill_row   = freed;
              r.fill_value = {attr, CH_SPACE};
            end
          end else begin
            cur_col = cur_col + 7'd1;
          end
          pos          = int'(cur_row) * COLUMNS + int'(cur_col);
          r.cursor_we  = 1'b1;
          r.cursor_pos = pos[10:0];
        end
      endcase
    end
    r.top_row = ring_top;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: register writes, result check, prediction on input transactions
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    string   bad;
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == CFG_TEXT_COLOR) attr = cfg_wdata;
        else gfx_off = cfg_wdata[0];
      end
      // result first: it belongs to an earlier input transaction
      if (out_tvalid && out_tready) begin
        got = out_tdata[RESULT_BITS-1:0];
        if (screen_ops_q.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing expected", got));
        end else begin
          want = screen_ops_q.pop_front();
          bad  = "";
          if (got.debug_byte !== want.debug_byte) bad = {bad, " debug_byte"};
          if (got.cell_we    !== want.cell_we)    bad = {bad, " cell_we"};
          if (got.cell_row   !== want.cell_row)   bad = {bad, " cell_row"};
          if (got.cell_col   !== want.cell_col)   bad = {bad, " cell_col"};
          if (got.cell_value !== want.cell_value) bad = {bad, " cell_value"};
          if (got.fill_we    !== want.fill_we)    bad = {bad, " fill_we"};
          if (got.fill_row   !== want.fill_row)   bad = {bad, " fill_row"};
          if (got.fill_value !== want.fill_value) bad = {bad, " fill_value"};
          if (got.top_row    !== want.top_row)    bad = {bad, " top_row"};
          if (got.cursor_we  !== want.cursor_we)  bad = {bad, " cursor_we"};
          if (got.cursor_pos !== want.cursor_pos) bad = {bad, " cursor_pos"};
          if (bad != "")
            report_mismatch($sformatf("char %h,%s: expected %h got %h",
                                      want.debug_byte, bad, want, got));
        end
      end
      if (in_tvalid && in_tready) screen_ops_q.push_back(console_step(in_tdata));
    end
  end

  // Receiver: random stall bursts while bursts are enabled
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (bursts_on && rst_n && $urandom_range(0, 15) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // One input transaction, with an optional gap in front of it. tvalid stays
  // high between back-to-back items; only a gap or a drain wait lowers it.
  task automatic send_char(input logic [7:0] ch);
    if (bursts_on && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Hold the sender until every predicted result is back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (screen_ops_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly printable text, with a fair share of control bytes and raw bytes
  function automatic logic [7:0] pick_char();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 8'($urandom_range(32, 126));
    if (sel < 72) return CH_NEWLINE;
    if (sel < 80) return CH_RETURN;
    if (sel < 92) return CH_BACKSPACE;
    return 8'($urandom_range(0, 255));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset colour, byte extremes, each control code, backspace at column 0
  task automatic test_directed();
    logic [7:0] seq [20];
    seq = '{CH_BACKSPACE, 8'h41, 8'h00, 8'hFF, 8'h80, 8'h7F, CH_SPACE, CH_BACKSPACE,
            CH_BACKSPACE, CH_BACKSPACE, 8'h7A, CH_RETURN, CH_BACKSPACE, 8'h71,
            CH_NEWLINE, CH_NEWLINE, 8'h01, 8'hFE, CH_RETURN, CH_NEWLINE};
    foreach (seq[i]) send_char(seq[i]);
  endtask

  // Attribute extremes and a random one
  task automatic test_colours();
    logic [7:0] shades [4];
    shades = '{8'h00, 8'hFF, 8'hA5, 8'($urandom_range(0, 255))};
    foreach (shades[i]) begin
      wait_drained();
      write_reg(CFG_TEXT_COLOR, shades[i]);
      repeat (20) send_char(pick_char());
    end
  endtask

  // Echo only; upper data bits are junk to check the one-bit register
  task automatic test_suppress();
    wait_drained();
    write_reg(CFG_GFX_SUPPRESS, {7'($urandom_range(0, 127)), 1'b1});
    send_char(CH_NEWLINE);
    send_char(CH_BACKSPACE);
    send_char(CH_RETURN);
    repeat (40) send_char(8'($urandom_range(0, 255)));
    wait_drained();
    write_reg(CFG_GFX_SUPPRESS, {7'($urandom_range(0, 127)), 1'b0});
    repeat (10) send_char(pick_char());
  endtask

  // Lines around the screen width: row wrap, backspace across it, scrolls
  task automatic test_long_lines();
    int len;
    repeat (6) begin
      len = $urandom_range(70, 90);
      repeat (len) begin
        if ($urandom_range(0, 9) == 0) send_char(CH_BACKSPACE);
        else send_char(8'($urandom_range(32, 255)));
      end
      case ($urandom_range(0, 2))
        0: send_char(CH_NEWLINE);
        1: send_char(CH_RETURN);
        default: ;
      endcase
    end
  endtask

  // Mixed text with colour changes and short suppressed stretches between phases
  task automatic test_random_text();
    repeat (5) begin
      repeat (100) send_char(pick_char());
      wait_drained();
      write_reg(CFG_TEXT_COLOR, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 0) begin
        write_reg(CFG_GFX_SUPPRESS, 8'h01);
        repeat (15) send_char(8'($urandom_range(0, 255)));
        wait_drained();
        write_reg(CFG_GFX_SUPPRESS, 8'h00);
      end
    end
  endtask

  // Sender holds off mid-stream until the output side has caught up
  task automatic test_drain_pause();
    repeat (3) begin
      repeat (15) send_char(pick_char());
      wait_drained();
    end
  endtask

  // Last stretch with no idling on either side
  task automatic test_back_to_back();
    bursts_on = 1'b0;
    repeat (150) send_char(pick_char());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_colours();
    test_suppress();
    test_long_lines();
    test_random_text();
    test_drain_pause();
    test_back_to_back();

    wait_drained();
    if (mismatches == 0) begin
      $display("[text_console_cursor_engine_top] OK");
    end else begin
      $display("[text_console_cursor_engine_top] ERROR");
    end
    $finish;
  end

endmodule
